### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while in reset
`define IPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define IPL_NEVER(lbl, cond, msg) \
	`IPL_ASSERT(lbl, !(cond), msg)

`endif

### src/ipl_pkg.sv
`default_nettype none

package ipl_pkg;

	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;

	localparam int CAPACITY_DEF = 16;

	localparam logic [OP_W-1:0] OP_ADD_FIRST = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_LAST  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ      = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} ipl_point_t;

	// per-cycle command broadcast along the cell chain
	typedef struct packed {
		logic ins;
		logic rem;
	} ipl_cmd_t;

endpackage

`default_nettype wire

### src/ipl_cell.sv
`default_nettype none

module ipl_cell #(
	parameter int IDX   = 0,
	parameter int PW    = 5
) (
	input  wire logic               clk,
	input  wire ipl_pkg::ipl_cmd_t   cmd,
	input  wire logic [PW-1:0]      pos,
	input  wire ipl_pkg::ipl_point_t new_pt,
	input  wire ipl_pkg::ipl_point_t left_pt,
	input  wire ipl_pkg::ipl_point_t right_pt,
	output ipl_pkg::ipl_point_t      pt_q
);
	import ipl_pkg::*;

	localparam logic [PW-1:0] IDX_EXT = PW'(IDX);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX_EXT > pos) begin
				pt_q <= left_pt;
			end else if (IDX_EXT == pos) begin
				pt_q <= new_pt;
			end
		end else if (cmd.rem && (IDX_EXT >= pos)) begin
			pt_q <= right_pt;
		end
	end

endmodule

`default_nettype wire

### src/indexed_point_list.sv
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless output stalls; every op is a single cell-chain step.
// in_ready stays high while the output register is empty or being taken.
// Reset clears the entry count and the output valid; cell contents are undefined until written.
`default_nettype none

`include "assert_macros.svh"

module indexed_point_list #(
	parameter int CAPACITY = ipl_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ipl_pkg::OP_W-1:0]      op,
	input  wire logic [ipl_pkg::POS_W-1:0]     position,
	input  wire logic [ipl_pkg::WORD_W-1:0]    in_x,
	input  wire logic [ipl_pkg::WORD_W-1:0]    in_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ipl_pkg::STATUS_W-1:0]       status,
	output logic [ipl_pkg::WORD_W-1:0]         out_x,
	output logic [ipl_pkg::WORD_W-1:0]         out_y,
	output logic [ipl_pkg::COUNT_W-1:0]        count
);
	import ipl_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_nxt;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_nxt;
	ipl_point_t          out_pt_q;
	ipl_point_t          out_pt_nxt;
	logic [COUNT_W-1:0]  count_q;

	logic                in_acc;
	logic                full;
	logic [CMPW-1:0]     pos_ext;
	logic [CMPW-1:0]     cnt_ext;
	logic [CMPW-1:0]     ins_pos;
	logic [CMPW-1:0]     cell_pos;
	logic [IW-1:0]       rd_idx;
	logic                do_ins;
	logic                do_rem;
	ipl_cmd_t            cmd;
	ipl_point_t          new_pt;
	ipl_point_t          cell_pt [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign full     = (cnt_q == CW'(CAPACITY));
	assign pos_ext  = CMPW'(position);
	assign cnt_ext  = CMPW'(cnt_q);
	assign rd_idx   = IW'(pos_ext);
	assign new_pt   = '{x: in_x, y: in_y};

	always_comb begin
		status_nxt = ST_OK;
		out_pt_nxt = '0;
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		ins_pos    = pos_ext;
		unique case (op) inside
			OP_ADD_FIRST: begin
				ins_pos = '0;
				if (full) status_nxt = ST_FULL;
				else      do_ins     = 1'b1;
			end
			OP_ADD_LAST: begin
				ins_pos = cnt_ext;
				if (full) status_nxt = ST_FULL;
				else      do_ins     = 1'b1;
			end
			OP_INSERT: begin
				if (full)                   status_nxt = ST_FULL;
				else if (pos_ext > cnt_ext) status_nxt = ST_BAD;
				else                        do_ins     = 1'b1;
			end
			OP_REMOVE, OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_nxt = ST_BAD;
				end else begin
					out_pt_nxt = cell_pt[rd_idx];
					do_rem     = (op == OP_REMOVE);
				end
			end
			default: status_nxt = ST_BAD;
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (do_ins)      cnt_nxt = cnt_q + 1'b1;
		else if (do_rem) cnt_nxt = cnt_q - 1'b1;
	end

	assign cmd.ins  = in_acc && do_ins;
	assign cmd.rem  = in_acc && do_rem;
	assign cell_pos = do_ins ? ins_pos : pos_ext;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ipl_point_t left_pt;
		ipl_point_t right_pt;
		if (i == 0) begin : g_first
			assign left_pt = new_pt;
		end else begin : g_mid_l
			assign left_pt = cell_pt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_pt = cell_pt[i];
		end else begin : g_mid_r
			assign right_pt = cell_pt[i+1];
		end
		ipl_cell #(
			.IDX (i),
			.PW  (CMPW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.pos      (cell_pos),
			.new_pt   (new_pt),
			.left_pt  (left_pt),
			.right_pt (right_pt),
			.pt_q     (cell_pt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= status_nxt;
			out_pt_q <= out_pt_nxt;
			count_q  <= COUNT_W'(cnt_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_x     = out_pt_q.x;
	assign out_y     = out_pt_q.y;
	assign count     = count_q;

	`IPL_NEVER(a_ins_rem_excl, cmd.ins && cmd.rem, "insert and remove in one cycle")
	`IPL_NEVER(a_cnt_range, cnt_q > CW'(CAPACITY), "entry count above capacity")
	`IPL_ASSERT(a_ins_count, cmd.ins |=> cnt_q == CW'($past(cnt_q) + 1'b1), "insert count")
	`IPL_ASSERT(a_rem_count, cmd.rem |=> cnt_q == CW'($past(cnt_q) - 1'b1), "remove count")
	`IPL_ASSERT(a_full_count, out_valid_q && status_q == ST_FULL |-> count_q == COUNT_W'(CAPACITY), "full count")

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ipl_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int TAIL_ITEMS   = 50;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} list_op_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   x;
		logic [WORD_W-1:0]   y;
		logic [COUNT_W-1:0]  count;
	} list_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op = '0;
	logic [POS_W-1:0]    position = '0;
	logic [WORD_W-1:0]   in_x = '0;
	logic [WORD_W-1:0]   in_y = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   out_x;
	logic [WORD_W-1:0]   out_y;
	logic [COUNT_W-1:0]  count;

	list_op_t    op_queue[$];
	list_reply_t reply_queue[$];

	ipl_point_t shadow_pts[CAPACITY_DEF];
	int         shadow_len = 0;

	int error_count = 0;
	int cycle_count = 0;
	int in_idle_left = 0;
	int in_idle_pct = 20;
	int out_idle_left = 0;
	int out_idle_pct = 20;
	int items_sent = 0;
	int replies_seen = 0;

	list_op_t    next_item;
	list_reply_t got_reply;
	list_reply_t want_reply;

	indexed_point_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.position  (position),
		.in_x      (in_x),
		.in_y      (in_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_x     (out_x),
		.out_y     (out_y),
		.count     (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void apply_list_op(logic [OP_W-1:0] o, logic [POS_W-1:0] p,
			logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
		list_reply_t r;
		bit          full;
		int          slot;
		int          i;
		r = '{ST_OK, '0, '0, '0};
		full = shadow_len >= CAPACITY_DEF;
		slot = -1;
		case (o) inside
			OP_ADD_FIRST: begin
				if (full) r.status = ST_FULL;
				else slot = 0;
			end
			OP_ADD_LAST: begin
				if (full) r.status = ST_FULL;
				else slot = shadow_len;
			end
			OP_INSERT: begin
				if (full) r.status = ST_FULL;
				else if (int'(p) > shadow_len) r.status = ST_BAD;
				else slot = int'(p);
			end
			OP_REMOVE, OP_READ: begin
				if (int'(p) >= shadow_len) begin
					r.status = ST_BAD;
				end else begin
					r.x = shadow_pts[p].x;
					r.y = shadow_pts[p].y;
					if (o == OP_REMOVE) begin
						for (i = int'(p); i + 1 < shadow_len; i++)
							shadow_pts[i] = shadow_pts[i+1];
						shadow_len--;
					end
				end
			end
			default: r.status = ST_BAD;
		endcase
		if (slot >= 0) begin
			for (i = shadow_len; i > slot; i--)
				shadow_pts[i] = shadow_pts[i-1];
			shadow_pts[slot].x = x;
			shadow_pts[slot].y = y;
			shadow_len++;
		end
		r.count = COUNT_W'(shadow_len);
		reply_queue.push_back(r);
	endfunction

	function automatic void queue_op(logic [OP_W-1:0] o, logic [POS_W-1:0] p,
			logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
		list_op_t it;
		it.op = o;
		it.pos = p;
		it.x = x;
		it.y = y;
		op_queue.push_back(it);
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return $urandom;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// input side
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				apply_list_op(op, position, in_x, in_y);
			if (!in_valid || in_ready) begin
				if (in_idle_left > 0) begin
					in_idle_left--;
					in_valid <= 1'b0;
				end else if (op_queue.size() >= TAIL_ITEMS &&
						$urandom_range(0, 99) < in_idle_pct) begin
					in_idle_left = $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else if (op_queue.size() > 0) begin
					next_item = op_queue.pop_front();
					in_valid <= 1'b1;
					op <= next_item.op;
					position <= next_item.pos;
					in_x <= next_item.x;
					in_y <= next_item.y;
					items_sent++;
					if (items_sent % 64 == 0)
						in_idle_pct = pick_idle_pct();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_reply = '{status, out_x, out_y, count};
				replies_seen++;
				if (replies_seen % 64 == 0)
					out_idle_pct = pick_idle_pct();
				if (reply_queue.size() == 0) begin
					$error("unexpected item: status %0d count %0d", status, count);
					error_count++;
				end else begin
					want_reply = reply_queue.pop_front();
					if (got_reply.status !== want_reply.status) begin
						$error("status: expected %0d, got %0d", want_reply.status,
							got_reply.status);
						error_count++;
					end
					if (got_reply.x !== want_reply.x) begin
						$error("out_x: expected %h, got %h", want_reply.x, got_reply.x);
						error_count++;
					end
					if (got_reply.y !== want_reply.y) begin
						$error("out_y: expected %h, got %h", want_reply.y, got_reply.y);
						error_count++;
					end
					if (got_reply.count !== want_reply.count) begin
						$error("count: expected %0d, got %0d", want_reply.count,
							got_reply.count);
						error_count++;
					end
				end
			end
			if (out_idle_left > 0) begin
				out_idle_left--;
				out_ready <= 1'b0;
			end else if (op_queue.size() >= TAIL_ITEMS &&
					$urandom_range(0, 99) < out_idle_pct) begin
				out_idle_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("indexed_point_list test failed");
			$finish;
		end
	end

	initial begin
		int               n;
		int               pick;
		int               gen_len;
		bit               filling;
		logic [OP_W-1:0]  g_op;
		logic [POS_W-1:0] g_pos;

		// empty list, unused codes
		queue_op(OP_READ, 5'd0, '0, '0);
		queue_op(OP_REMOVE, 5'd0, '0, '0);
		queue_op(3'd7, 5'd31, '1, '1);
		// basic placement and position checks
		queue_op(OP_ADD_LAST, 5'd0, '0, '0);
		queue_op(OP_ADD_FIRST, 5'd0, '1, '1);
		queue_op(OP_INSERT, 5'd1, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		queue_op(OP_INSERT, 5'd3, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_op(OP_INSERT, 5'd5, 32'hDEAD_BEEF, 32'hCAFE_F00D);
		queue_op(OP_READ, 5'd3, '0, '0);
		queue_op(OP_REMOVE, 5'd1, '0, '0);
		// fill to capacity, then hit the full cases
		for (n = 0; n < CAPACITY_DEF - 3; n++)
			queue_op(n[0] ? OP_ADD_FIRST : OP_ADD_LAST, 5'd0, $urandom, $urandom);
		queue_op(OP_ADD_FIRST, 5'd0, '1, '0);
		queue_op(OP_INSERT, 5'd16, '0, '1);
		queue_op(OP_READ, 5'd15, '0, '0);

		gen_len = CAPACITY_DEF;
		filling = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (gen_len == CAPACITY_DEF && $urandom_range(0, 3) == 0) filling = 1'b0;
			if (gen_len == 0) filling = 1'b1;
			if ($urandom_range(0, 39) == 0) filling = !filling;
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				g_op = OP_W'($urandom_range(0, 7));
				g_pos = POS_W'($urandom_range(0, 31));
			end else begin
				pick = $urandom_range(0, 99);
				if (filling)
					g_op = pick < 25 ? OP_ADD_FIRST : pick < 50 ? OP_ADD_LAST :
						pick < 75 ? OP_INSERT : pick < 85 ? OP_REMOVE : OP_READ;
				else
					g_op = pick < 10 ? OP_ADD_FIRST : pick < 20 ? OP_INSERT :
						pick < 70 ? OP_REMOVE : OP_READ;
				if ($urandom_range(0, 19) == 0)
					g_pos = POS_W'($urandom_range(0, 31));
				else if (g_op == OP_INSERT)
					g_pos = POS_W'($urandom_range(0, gen_len));
				else
					g_pos = gen_len == 0 ? '0 : POS_W'($urandom_range(0, gen_len - 1));
			end
			queue_op(g_op, g_pos, rand_word(), rand_word());
			case (g_op) inside
				OP_ADD_FIRST, OP_ADD_LAST: if (gen_len < CAPACITY_DEF) gen_len++;
				OP_INSERT: if (gen_len < CAPACITY_DEF && int'(g_pos) <= gen_len) gen_len++;
				OP_REMOVE: if (int'(g_pos) < gen_len) gen_len--;
				default: ;
			endcase
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (op_queue.size() > 0 || in_valid) @(posedge clk);
		while (reply_queue.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);

		if (error_count == 0)
			$display("indexed_point_list test passed");
		else
			$display("indexed_point_list test failed");
		$finish;
	end

endmodule
